>>> sv/stt_pkg.sv
// Shared types and constants for the source text tokenizer.
`default_nettype none

package stt_pkg;

    localparam int OFFSET_BITS_DEF = 16;   // default width of offset and length counters
    localparam int CHAR_BITS       = 8;
    localparam int TOK_BITS        = 16;   // start and length fields on the output bus
    localparam int KIND_BITS       = 4;
    localparam int S_TDATA_BITS    = 8;
    localparam int M_TDATA_BITS    = 40;   // 36 bits of fields, padded to whole bytes
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_IDENT   = 4'd0,
        KIND_FN      = 4'd1,
        KIND_IF      = 4'd2,
        KIND_ELSE    = 4'd3,
        KIND_NUMBER  = 4'd4,
        KIND_PLUS    = 4'd5,
        KIND_MINUS   = 4'd6,
        KIND_STAR    = 4'd7,
        KIND_SLASH   = 4'd8,
        KIND_LPAREN  = 4'd9,
        KIND_RPAREN  = 4'd10,
        KIND_COMMA   = 4'd11,
        KIND_LBRACE  = 4'd12,
        KIND_RBRACE  = 4'd13,
        KIND_EQUAL   = 4'd14,
        KIND_UNKNOWN = 4'd15
    } t_kind;

    // one token as it sits in the output queue
    typedef struct packed {
        t_kind               kind;
        logic [TOK_BITS-1:0] start;
        logic [TOK_BITS-1:0] length;
        logic                last;
    } t_tok;

    // tokens produced by one byte, tok0 goes out first
    typedef struct packed {
        logic [1:0] num;
        t_tok       tok1;
        t_tok       tok0;
    } t_push;

endpackage

`default_nettype wire

>>> sv/stt_scan.sv
// Byte scanner: input register, scan state and per-byte token decisions.
`default_nettype none

module stt_scan
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_valid,
    output logic                     o_s_ready,
    input  logic [CHAR_BITS-1:0]     i_char,
    input  logic                     i_eot,
    input  logic [FIFO_CNT_BITS-1:0] i_space,
    output t_push                    o_push
);

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_IDENT = 4'b0010,
        MODE_INT   = 4'b0100,
        MODE_FRAC  = 4'b1000
    } t_mode;

    // keyword prefix tracker
    typedef enum logic [8:0] {
        KW_NONE = 9'b000000001,
        KW_F    = 9'b000000010,
        KW_FN   = 9'b000000100,
        KW_I    = 9'b000001000,
        KW_IF   = 9'b000010000,
        KW_E    = 9'b000100000,
        KW_EL   = 9'b001000000,
        KW_ELS  = 9'b010000000,
        KW_ELSE = 9'b100000000
    } t_kw;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? v : v + OFF_ONE;
    endfunction

    function automatic logic [TOK_BITS-1:0] fit(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[TOK_BITS-1:0];
    endfunction

    function automatic t_kind sym_kind(input logic [CHAR_BITS-1:0] c);
        case (c)
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            ",":     return KIND_COMMA;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            "=":     return KIND_EQUAL;
            default: return KIND_UNKNOWN;
        endcase
    endfunction

    function automatic t_kw kw_first(input logic [CHAR_BITS-1:0] c);
        case (c)
            "f":     return KW_F;
            "i":     return KW_I;
            "e":     return KW_E;
            default: return KW_NONE;
        endcase
    endfunction

    function automatic t_kw kw_next(input t_kw p, input logic [CHAR_BITS-1:0] c);
        case (p)
            KW_F:    return (c == "n") ? KW_FN   : KW_NONE;
            KW_I:    return (c == "f") ? KW_IF   : KW_NONE;
            KW_E:    return (c == "l") ? KW_EL   : KW_NONE;
            KW_EL:   return (c == "s") ? KW_ELS  : KW_NONE;
            KW_ELS:  return (c == "e") ? KW_ELSE : KW_NONE;
            default: return KW_NONE;
        endcase
    endfunction

    function automatic t_kind word_kind(input t_mode m, input t_kw k);
        if (m != MODE_IDENT) begin
            return KIND_NUMBER;
        end
        case (k)
            KW_FN:   return KIND_FN;
            KW_IF:   return KIND_IF;
            KW_ELSE: return KIND_ELSE;
            default: return KIND_IDENT;
        endcase
    endfunction

    // input register
    logic                   r_vld;
    logic [CHAR_BITS-1:0]   r_char;
    logic                   r_eot;

    // scan state
    t_mode                  r_mode, n_mode;
    t_kw                    r_kw, n_kw;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [OFFSET_BITS-1:0] r_len, n_len;

    logic is_letter, is_digit, is_space, is_dot, is_word, is_sym;
    logic ext_id, ext_num, to_frac, extend;
    logic have_a, have_b, have_c;
    logic [1:0] need;
    logic go;
    t_kind sym;
    t_mode                  p_mode;
    t_kw                    p_kw;
    logic [OFFSET_BITS-1:0] p_start, p_len;
    t_tok tok_a, tok_b, tok_c;

    always_comb begin
        is_letter = (r_char inside {["a":"z"], ["A":"Z"]});
        is_digit  = (r_char inside {["0":"9"]});
        is_space  = (r_char inside {" ", [8'd9:8'd13]});
        is_dot    = (r_char == ".");
        is_word   = is_letter || (r_char == "_");
        sym       = sym_kind(r_char);
        is_sym    = (sym != KIND_UNKNOWN);

        ext_id  = (r_mode == MODE_IDENT) && (is_word || is_digit);
        ext_num = ((r_mode == MODE_INT) || (r_mode == MODE_FRAC)) && is_digit;
        to_frac = (r_mode == MODE_INT) && is_dot;
        extend  = ext_id || ext_num || to_frac;

        // pending token after this byte, before any end-of-text flush
        p_mode  = MODE_IDLE;
        p_kw    = KW_NONE;
        p_start = r_start;
        p_len   = '0;
        if (ext_id) begin
            p_mode  = MODE_IDENT;
            p_kw    = kw_next(r_kw, r_char);
            p_len   = sat_inc(r_len);
        end else if (ext_num) begin
            p_mode  = r_mode;
            p_len   = sat_inc(r_len);
        end else if (to_frac) begin
            p_mode  = MODE_FRAC;
            p_len   = sat_inc(r_len);
        end else if (is_word) begin
            p_mode  = MODE_IDENT;
            p_kw    = kw_first(r_char);
            p_start = r_off;
            p_len   = OFF_ONE;
        end else if (is_digit) begin
            p_mode  = MODE_INT;
            p_start = r_off;
            p_len   = OFF_ONE;
        end else if (is_dot) begin
            p_mode  = MODE_FRAC;
            p_start = r_off;
            p_len   = OFF_ONE;
        end

        // a: old token closed by this byte; b: symbol or unknown; c: flush at end of text
        have_a = !extend && (r_mode != MODE_IDLE);
        have_b = !extend && !is_space && !is_word && !is_digit && !is_dot;
        have_c = r_eot && (p_mode != MODE_IDLE);
        need   = {1'b0, have_a} + {1'b0, (have_b || have_c)};

        tok_a.kind   = word_kind(r_mode, r_kw);
        tok_a.start  = fit(r_start);
        tok_a.length = fit(r_len);
        tok_a.last   = 1'b0;
        tok_b.kind   = is_sym ? sym : KIND_UNKNOWN;
        tok_b.start  = fit(r_off);
        tok_b.length = fit(OFF_ONE);
        tok_b.last   = 1'b1;
        tok_c.kind   = word_kind(p_mode, p_kw);
        tok_c.start  = fit(p_start);
        tok_c.length = fit(p_len);
        tok_c.last   = 1'b1;

        go        = r_vld && ({1'b0, need} <= i_space);
        o_s_ready = !r_vld || go;

        o_push.num  = go ? need : 2'd0;
        o_push.tok0 = have_a ? tok_a : (have_b ? tok_b : tok_c);
        o_push.tok0.last = (need == 2'd1);
        o_push.tok1 = have_b ? tok_b : tok_c;

        n_mode  = r_mode;
        n_kw    = r_kw;
        n_start = r_start;
        n_len   = r_len;
        n_off   = r_off;
        if (go) begin
            n_start = p_start;
            if (r_eot) begin
                n_mode = MODE_IDLE;
                n_kw   = KW_NONE;
                n_len  = '0;
                n_off  = '0;
            end else begin
                n_mode = p_mode;
                n_kw   = p_kw;
                n_len  = p_len;
                n_off  = sat_inc(r_off);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_mode  <= MODE_IDLE;
            r_kw    <= KW_NONE;
            r_off   <= '0;
            r_start <= '0;
            r_len   <= '0;
        end else begin
            if (o_s_ready) begin
                r_vld <= i_s_valid;
            end
            r_mode  <= n_mode;
            r_kw    <= n_kw;
            r_off   <= n_off;
            r_start <= n_start;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_ready && i_s_valid) begin
            r_char <= i_char;
            r_eot  <= i_eot;
        end
    end

`ifndef SYNTHESIS
    a_eot_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && r_eot |=> (r_off == '0) && (r_mode == MODE_IDLE))
        else $error("end of text did not rewind the scanner");

    a_pending_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_IDLE) |-> (r_len != '0))
        else $error("pending token with zero length");

    a_last_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.num == 2'd2) |-> (o_push.tok1.last && !o_push.tok0.last))
        else $error("last flag on wrong token of a pair");
`endif

endmodule

`default_nettype wire

>>> sv/stt_fifo.sv
// Output token queue: takes up to two tokens per cycle, sends one per beat.
`default_nettype none

module stt_fifo
    import stt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_push                    i_push,
    output logic [FIFO_CNT_BITS-1:0] o_space,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_tok                     o_tok
);

    localparam logic [FIFO_PTR_BITS-1:0] PTR_ONE = FIFO_PTR_BITS'(1);
    localparam logic [FIFO_CNT_BITS-1:0] CNT_DEPTH = FIFO_CNT_BITS'(FIFO_DEPTH);

    t_tok                     r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wp, n_wp;
    logic [FIFO_PTR_BITS-1:0] r_rp, n_rp;
    logic [FIFO_CNT_BITS-1:0] r_count, n_count;
    logic                     pop;

    always_comb begin
        o_valid = (r_count != '0);
        o_tok   = r_mem[r_rp];
        pop     = o_valid && i_ready;
        // slots free this cycle, counting the one freed by a pop
        o_space = CNT_DEPTH - r_count + FIFO_CNT_BITS'(pop);
        n_wp    = r_wp + FIFO_PTR_BITS'(i_push.num);
        n_rp    = pop ? r_rp + PTR_ONE : r_rp;
        n_count = r_count + FIFO_CNT_BITS'(i_push.num) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wp] <= i_push.tok0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wp + PTR_ONE] <= i_push.tok1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, i_push.num} <= {1'b0, o_space})
        else $error("token queue overflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_DEPTH)
        else $error("token queue count out of range");
`endif

endmodule

`default_nettype wire

>>> sv/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
//
// Slave side: one ASCII byte per beat in tdata, tlast marks the final byte
// of a text. Master side: one token per beat, kind, start offset and length
// in tdata; tlast marks the last token caused by a given input byte.
// A byte produces zero, one or two tokens. A token is sent after the byte
// that ends it arrives, or with its own last byte when that byte has tlast.
// Keywords fn, if and else are recognized with a prefix tracker.
// A token is offered on the master side once the byte that causes it has
// been accepted: the byte is held in the input register, its tokens are
// then written into the token queue, and a token waits longer only while
// older tokens are still queued ahead of it.
// Throughput: one byte per cycle sustained while the queue has room; each
// byte is decided by the logic between the input register and a four-entry
// token queue. The queue absorbs the two-token bursts; a byte waits in the
// input register only while the queue lacks room for its tokens, which
// happens when the receiver stalls. Stalls never drop or repeat tokens.
// Reset (synchronous, active low) empties both stages, returns the scanner
// to idle and sets the byte offset to zero. Offsets and lengths saturate at
// 2^OFFSET_BITS - 1; after a tlast byte the offset restarts at zero.
`default_nettype none

module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [S_TDATA_BITS-1:0] i_s_axis_tdata,  // [7:0] char_code
    input  logic                    i_s_axis_tlast,  // end_of_text
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [M_TDATA_BITS-1:0] o_m_axis_tdata,  // [3:0] kind, [19:4] start,
                                                     // [35:20] length, [39:36] zero
    output logic                    o_m_axis_tlast   // run_last
);

    t_push                    push;
    logic [FIFO_CNT_BITS-1:0] space;
    t_tok                     head;

    stt_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_char    (i_s_axis_tdata[CHAR_BITS-1:0]),
        .i_eot     (i_s_axis_tlast),
        .i_space   (space),
        .o_push    (push)
    );

    stt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_tok   (head)
    );

    assign o_m_axis_tdata = {4'b0000, head.length, head.start, head.kind};
    assign o_m_axis_tlast = head.last;

endmodule

`default_nettype wire
